// ===== hw/rtl/sks_pkg.sv =====
package sks_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned POS_W = 6;

  typedef struct packed {
    logic [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0] location_tag;
    logic             segment_last;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0] sorted_tag;
    logic [POS_W-1:0] original_position;
    logic             result_last;
  } out_word_t;

  // One entry of the sorting chain.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] code;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] pos;
  } entry_t;

  // Map raw double bits to an unsigned code in numeric order; -0 folds to +0.
  function automatic logic [KEY_W-1:0] order_code(input logic [KEY_W-1:0] bits);
    logic [KEY_W-1:0] b;
    b = bits;
    if (b == {1'b1, {(KEY_W-1){1'b0}}}) b = '0;
    if (b[KEY_W-1]) return ~b;
    return b ^ {1'b1, {(KEY_W-1){1'b0}}};
  endfunction

endpackage

// ===== hw/rtl/sks_stream_if.sv =====
interface sks_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sks_cell.sv =====
// One insertion cell. In insert mode it keeps the smaller of its entry and the
// incoming one (lower arrival position wins ties) and passes the other on. In
// shift mode it takes its left neighbor's entry, and clear empties the cell.
module sks_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            insert,
  input  logic            shift,
  input  logic            clear,
  input  sks_pkg::entry_t pass_in,
  input  sks_pkg::entry_t left_in,
  output sks_pkg::entry_t pass_out,
  output sks_pkg::entry_t held
);
  sks_pkg::entry_t cur;
  sks_pkg::entry_t fwd;
  logic            take;

  assign held = cur;

  always_comb begin
    // Displaced words can overtake newer ones, so break ties by arrival position.
    take = pass_in.valid && (!cur.valid || (pass_in.code < cur.code) ||
           ((pass_in.code == cur.code) && (pass_in.pos < cur.pos)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
      fwd.valid <= 1'b0;
    end else if (clear) begin
      cur.valid <= 1'b0;
      fwd.valid <= 1'b0;
    end else if (shift) begin
      cur <= left_in;
      fwd.valid <= 1'b0;
    end else if (insert) begin
      if (take) begin
        cur <= pass_in;
        fwd <= cur;
      end else begin
        fwd <= pass_in;
      end
    end
  end

  assign pass_out = fwd;
endmodule

// ===== hw/rtl/segment_key_sorter.sv =====
// Output: after a segment's last item is accepted the sorter waits in SETTLE
// while the chain settles, then results leave one per cycle while the sink is
// ready.
// Throughput: one item per cycle while a segment fills; no items are accepted
// in SETTLE or DRAIN, as in_ch.ready is high only in FILL.
// Reset: synchronous, clears the cell valid bits, the fill count and control.
module segment_key_sorter #(
  parameter int MAX_SEGMENT = 64
) (
  input logic clk,
  input logic rst,
  sks_stream_if.sink   in_ch,
  sks_stream_if.source out_ch
);
  localparam int CNT_W = $clog2(MAX_SEGMENT + 1);

  typedef enum logic [1:0] {FILL, SETTLE, DRAIN} state_t;

  state_t               state;
  logic [CNT_W-1:0]     fill_count;
  logic [CNT_W-1:0]     timer;
  logic [CNT_W-1:0]     remain;

  sks_pkg::entry_t pass [MAX_SEGMENT+1];
  sks_pkg::entry_t held [MAX_SEGMENT];
  sks_pkg::entry_t left [MAX_SEGMENT];
  sks_pkg::entry_t ins;
  sks_pkg::in_word_t iw;

  logic accept;
  logic shift;
  logic out_fire;

  assign iw       = in_ch.data;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == FILL);
  assign out_fire = out_ch.valid && out_ch.ready;
  assign shift    = out_fire;

  always_comb begin
    ins.valid = accept && (fill_count < CNT_W'(MAX_SEGMENT));
    ins.code  = sks_pkg::order_code(iw.sort_key);
    ins.key   = iw.sort_key;
    ins.tag   = iw.location_tag;
    ins.pos   = sks_pkg::POS_W'(fill_count);
  end

  assign pass[0] = ins;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENT; g++) begin : g_cell
      if (g == MAX_SEGMENT - 1) begin : g_end
        assign left[g] = '0;
      end else begin : g_mid
        assign left[g] = held[g+1];
      end
      sks_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .insert   (state != DRAIN),
        .shift    (shift),
        .clear    (1'b0),
        .pass_in  (pass[g]),
        .left_in  (left[g]),
        .pass_out (pass[g+1]),
        .held     (held[g])
      );
    end
  endgenerate

  assign out_ch.valid = (state == DRAIN);
  assign out_ch.data  = '{sorted_key: held[0].key, sorted_tag: held[0].tag,
                          original_position: held[0].pos,
                          result_last: (remain == CNT_W'(1))};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FILL;
      fill_count <= '0;
      timer      <= '0;
      remain     <= '0;
    end else begin
      case (state)
        FILL: begin
          if (accept) begin
            if (fill_count < CNT_W'(MAX_SEGMENT)) fill_count <= fill_count + 1'b1;
            if (iw.segment_last) begin
              remain <= (fill_count < CNT_W'(MAX_SEGMENT)) ?
                        fill_count + 1'b1 : fill_count;
              timer  <= CNT_W'(MAX_SEGMENT);
              state  <= SETTLE;
            end
          end
        end
        SETTLE: begin
          // Let the last inserted word ripple to its cell.
          if (timer == '0) state <= DRAIN;
          else timer <= timer - 1'b1;
        end
        DRAIN: begin
          if (out_fire) begin
            remain <= remain - 1'b1;
            if (remain == CNT_W'(1)) begin
              fill_count <= '0;
              state      <= FILL;
            end
          end
        end
        default: state <= FILL;
      endcase
    end
  end
endmodule
